### hw/rtl/snfcs_pkg.sv
// ---------------------------------------------------------------------------
// snfcs_pkg
// shared types and constants for the spi nor flash command sequencer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package snfcs_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int MAX_RES     = 7;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      ACT_READ_ID  = 3'd0,
      ACT_READ     = 3'd1,
      ACT_PROGRAM  = 3'd2,
      ACT_ERASE    = 3'd3,
      ACT_CHIP     = 3'd4,
      ACT_PROT     = 3'd5,
      ACT_PAYLOAD  = 3'd6,
      ACT_REPLY    = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      PH_IDLE, PH_ID, PH_READ, PH_PAYLOAD, PH_POLL
   } phase_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_ID, OP_READ, OP_PAGE, OP_WORD, OP_ERASE, OP_PROT
   } op_type;

   localparam logic [7:0] OPC_RDSR  = 8'h05;
   localparam logic [7:0] OPC_EWSR  = 8'h50;
   localparam logic [7:0] OPC_WRDI  = 8'h04;
   localparam logic [7:0] OPC_WREN  = 8'h06;
   localparam logic [7:0] OPC_READ  = 8'h03;
   localparam logic [7:0] OPC_PP    = 8'h02;
   localparam logic [7:0] OPC_AAI   = 8'hAD;
   localparam logic [7:0] OPC_SE4K  = 8'h20;
   localparam logic [7:0] OPC_SE64K = 8'hD8;
   localparam logic [7:0] OPC_CE    = 8'hC7;
   localparam logic [7:0] OPC_RDID  = 8'h9F;
   localparam logic [7:0] OPC_DUMMY = 8'hFF;
   localparam logic [7:0] WRSR_ARG  = 8'h01;

   localparam int RES_BITS = 1 + 8 + 1 + 1 + 1 + 8 + 1 + 24 + 1 + 1 + 1;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        release_cs;
      logic        await_reply;
      logic        read_valid;
      logic [7:0]  read_byte;
      logic        id_valid;
      logic [23:0] device_id;
      logic        op_done;
      logic        error;
      logic        last;
   } result_type;

   typedef struct packed {
      action_type              action;
      logic [23:0]             address;
      logic [COUNT_WIDTH-1:0]  byte_count;
      logic [7:0]              data;
   } item_type;

endpackage

### hw/rtl/spi_nor_flash_command_sequencer_top.sv
// ---------------------------------------------------------------------------
// spi_nor_flash_command_sequencer_top
// spi nor flash command sequencer: requests in, spi byte frames and data out
// ---------------------------------------------------------------------------
// request path: the queue stores each request, then the sequencer registers its
//   result list
// results: one result per cycle while rsp_tready is high; an item gives 1 to 7
//   results, and the next item is taken as the last result of the current one leaves
// reset: synchronous active high; sequencer idle, registers at reset values
`timescale 1ns / 1ps
module spi_nor_flash_command_sequencer_top (
   input  logic         clock,
   input  logic         reset,
   // configuration writes
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [23:0]  csr_wdata,
   // request items
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,  // action, address, byte_count, payload, reply
   // result items
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,  // tx_valid, tx_byte, release_cs, await_reply,
                                    // read_valid, read_byte, id_valid, device_id,
                                    // op_done, error
   output logic         rsp_tlast
);
   import snfcs_pkg::*;

   logic        mode_ff;
   logic [23:0] large_ff;
   item_type    in_item, q_item;
   logic        q_valid, q_ready;
   result_type  res;

   // register index 0 is word mode, index 1 is the large sector boundary
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         large_ff <= 24'h010000;
      end else if (csr_we) begin
         if (!csr_index) mode_ff <= csr_wdata[0];
         else large_ff <= csr_wdata;
      end
   end

   // payload and reply share the data byte: only one is meaningful per action
   always_comb begin
      in_item.action     = action_type'(req_tdata[2:0]);
      in_item.address    = req_tdata[26:3];
      in_item.byte_count = req_tdata[42:27];
      in_item.data       = (req_tdata[2:0] == 3'(ACT_REPLY)) ? req_tdata[58:51]
                                                             : req_tdata[50:43];
   end

   snfcs_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(in_item),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
   );

   snfcs_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
      .word_mode(mode_ff), .large_start(large_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res)
   );

   assign rsp_tdata = {1'b0, res.error, res.op_done, res.device_id, res.id_valid,
                       res.read_byte, res.read_valid, res.await_reply, res.release_cs,
                       res.tx_byte, res.tx_valid};
   assign rsp_tlast = res.last;

endmodule

### hw/rtl/snfcs_front.sv
// ---------------------------------------------------------------------------
// snfcs_front
// accepts request items and queues them for the sequencer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module snfcs_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  snfcs_pkg::item_type  in_item,
   output logic                 q_valid,
   input  logic                 q_ready,
   output snfcs_pkg::item_type  q_item
);
   import snfcs_pkg::*;

   item_type   slot_ff [QUEUE_DEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = slot_ff[rp_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wp_ff] <= in_item;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
   a_empty_no_pop: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("pop from empty queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count slip");
`endif
endmodule

### hw/rtl/snfcs_back.sv
// ---------------------------------------------------------------------------
// snfcs_back
// carries out one queued item, emitting its results one per cycle while out_ready is high
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module snfcs_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   output logic                        q_ready,
   input  snfcs_pkg::item_type         q_item,
   input  logic                        word_mode,
   input  logic [23:0]                 large_start,
   output logic                        out_valid,
   input  logic                        out_ready,
   output snfcs_pkg::result_type       out_res
);
   import snfcs_pkg::*;

   phase_type              phase_ff, phase_in;
   op_type                 op_ff, op_in;
   logic [23:0]            addr_ff, addr_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [23:0]            id_ff, id_in;
   logic                   wbi_ff, wbi_in;

   // result list of the item in progress
   result_type             list_ff [MAX_RES];
   result_type             list_in [MAX_RES];
   logic [2:0]             num_ff, num_in, pos_ff, pos_in;
   logic                   busy_ff, busy_in;
   logic [2:0]             n;
   logic                   take;
   logic [COUNT_WIDTH-1:0] cnt, rem_dec;
   logic [7:0]             dat;

   // the next item is taken while the last result of the current one leaves
   assign q_ready   = !busy_ff || (out_ready && pos_ff == num_ff - 3'd1);
   assign take      = q_valid && q_ready;
   assign out_valid = busy_ff;
   assign out_res   = list_ff[pos_ff];
   assign cnt       = q_item.byte_count;
   assign dat       = q_item.data;
   assign rem_dec   = rem_ff - 1'b1;

   function automatic result_type tx(input logic [7:0] b, input logic rel, input logic aw);
      result_type r;
      r = '0;
      r.tx_valid = 1'b1;
      r.tx_byte = b;
      r.release_cs = rel;
      r.await_reply = aw;
      return r;
   endfunction

   always_comb begin
      result_type e;
      e        = '0;
      phase_in = phase_ff;
      op_in    = op_ff;
      addr_in  = addr_ff;
      rem_in   = rem_ff;
      id_in    = id_ff;
      wbi_in   = wbi_ff;
      for (int i = 0; i < MAX_RES; i++) list_in[i] = '0;
      n        = 3'd0;
      if (q_item.action != ACT_PAYLOAD && q_item.action != ACT_REPLY) begin
         if (phase_ff != PH_IDLE) begin
            list_in[0].error = 1'b1; n = 3'd1;
         end else begin
            unique case (q_item.action)
               ACT_READ_ID: begin
                  op_in = OP_ID; id_in = '0; rem_in = COUNT_WIDTH'(3);
                  list_in[0] = tx(OPC_RDID, 1'b0, 1'b0);
                  list_in[1] = tx(OPC_DUMMY, 1'b0, 1'b1);
                  n = 3'd2; phase_in = PH_ID;
               end
               ACT_READ: begin
                  if (cnt == '0) begin
                     list_in[0].op_done = 1'b1; n = 3'd1;
                     phase_in = PH_IDLE; op_in = OP_NONE;
                  end else begin
                     op_in = OP_READ; addr_in = q_item.address; rem_in = cnt;
                     list_in[0] = tx(OPC_READ, 1'b0, 1'b0);
                     list_in[1] = tx(q_item.address[23:16], 1'b0, 1'b0);
                     list_in[2] = tx(q_item.address[15:8], 1'b0, 1'b0);
                     list_in[3] = tx(q_item.address[7:0], 1'b0, 1'b0);
                     list_in[4] = tx(OPC_DUMMY, cnt == COUNT_WIDTH'(1), 1'b1);
                     n = 3'd5; phase_in = PH_READ;
                  end
               end
               ACT_PROGRAM: begin
                  if ((word_mode ? {cnt[COUNT_WIDTH-1:1], 1'b0} : cnt) == '0) begin
                     list_in[0].op_done = 1'b1; n = 3'd1;
                     phase_in = PH_IDLE; op_in = OP_NONE;
                  end else begin
                     op_in   = word_mode ? OP_WORD : OP_PAGE;
                     addr_in = q_item.address;
                     rem_in  = word_mode ? {cnt[COUNT_WIDTH-1:1], 1'b0} : cnt;
                     wbi_in  = 1'b0;
                     list_in[0] = tx(OPC_WREN, 1'b1, 1'b0);
                     list_in[1] = tx(word_mode ? OPC_AAI : OPC_PP, 1'b0, 1'b0);
                     list_in[2] = tx(q_item.address[23:16], 1'b0, 1'b0);
                     list_in[3] = tx(q_item.address[15:8], 1'b0, 1'b0);
                     list_in[4] = tx(q_item.address[7:0], 1'b0, 1'b0);
                     n = 3'd5; phase_in = PH_PAYLOAD;
                  end
               end
               ACT_ERASE: begin
                  op_in = OP_ERASE; addr_in = q_item.address;
                  list_in[0] = tx(OPC_WREN, 1'b1, 1'b0);
                  list_in[1] = tx((q_item.address >= large_start) ? OPC_SE64K : OPC_SE4K,
                                  1'b0, 1'b0);
                  list_in[2] = tx(q_item.address[23:16], 1'b0, 1'b0);
                  list_in[3] = tx(q_item.address[15:8], 1'b0, 1'b0);
                  list_in[4] = tx(q_item.address[7:0], 1'b1, 1'b0);
                  list_in[5] = tx(OPC_RDSR, 1'b0, 1'b0);
                  list_in[6] = tx(OPC_DUMMY, 1'b0, 1'b1);
                  n = 3'd7; phase_in = PH_POLL;
               end
               ACT_CHIP: begin
                  op_in = OP_ERASE;
                  list_in[0] = tx(OPC_WREN, 1'b1, 1'b0);
                  list_in[1] = tx(OPC_CE, 1'b1, 1'b0);
                  list_in[2] = tx(OPC_RDSR, 1'b0, 1'b0);
                  list_in[3] = tx(OPC_DUMMY, 1'b0, 1'b1);
                  n = 3'd4; phase_in = PH_POLL;
               end
               default: begin
                  list_in[0] = tx(OPC_EWSR, 1'b1, 1'b0);
                  list_in[1] = tx(WRSR_ARG, 1'b0, 1'b0);
                  list_in[2] = tx(8'h00, 1'b1, 1'b0);
                  list_in[2].op_done = 1'b1;
                  n = 3'd3; phase_in = PH_IDLE; op_in = OP_NONE;
               end
            endcase
         end
      end else if (q_item.action == ACT_PAYLOAD) begin
         if (phase_ff != PH_PAYLOAD) begin
            list_in[0].error = 1'b1; n = 3'd1;
         end else begin
            addr_in = addr_ff + 24'd1;
            rem_in  = rem_dec;
            if (op_ff == OP_WORD && !wbi_ff) begin
               list_in[0] = tx(dat, 1'b0, 1'b0); n = 3'd1; wbi_in = 1'b1;
            end else if (op_ff == OP_WORD || rem_dec == '0) begin
               wbi_in = 1'b0;
               list_in[0] = tx(dat, 1'b1, 1'b0);
               list_in[1] = tx(OPC_RDSR, 1'b0, 1'b0);
               list_in[2] = tx(OPC_DUMMY, 1'b0, 1'b1);
               n = 3'd3; phase_in = PH_POLL;
            end else begin
               list_in[0] = tx(dat, 1'b0, 1'b0); n = 3'd1;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_ID: begin
               id_in  = {id_ff[15:0], dat};
               rem_in = rem_dec;
               if (rem_dec == '0) begin
                  e.id_valid = 1'b1; e.device_id = {id_ff[15:0], dat};
                  e.op_done = 1'b1; list_in[0] = e; n = 3'd1;
                  phase_in = PH_IDLE; op_in = OP_NONE;
               end else begin
                  list_in[0] = tx(OPC_DUMMY, rem_dec == COUNT_WIDTH'(1), 1'b1); n = 3'd1;
               end
            end
            PH_READ: begin
               addr_in = addr_ff + 24'd1;
               rem_in  = rem_dec;
               if (rem_dec == '0) begin
                  e.op_done = 1'b1;
                  phase_in = PH_IDLE; op_in = OP_NONE;
               end else begin
                  e = tx(OPC_DUMMY, rem_dec == COUNT_WIDTH'(1), 1'b1);
               end
               e.read_valid = 1'b1; e.read_byte = dat;
               list_in[0] = e; n = 3'd1;
            end
            PH_POLL: begin
               if (dat[0]) begin
                  list_in[0] = tx(OPC_DUMMY, 1'b0, 1'b1); n = 3'd1;
               end else begin
                  list_in[0].release_cs = 1'b1;
                  if (op_ff == OP_WORD && rem_ff != '0) begin
                     list_in[1] = tx(OPC_AAI, 1'b0, 1'b0); n = 3'd2;
                     phase_in = PH_PAYLOAD;
                  end else if (op_ff == OP_WORD || op_ff == OP_PAGE) begin
                     list_in[1] = tx(OPC_WRDI, 1'b1, 1'b0);
                     list_in[1].op_done = 1'b1; n = 3'd2;
                     phase_in = PH_IDLE; op_in = OP_NONE;
                  end else begin
                     list_in[0].op_done = 1'b1; n = 3'd1;
                     phase_in = PH_IDLE; op_in = OP_NONE;
                  end
               end
            end
            default: begin
               list_in[0].error = 1'b1; n = 3'd1;
            end
         endcase
      end
      for (int i = 0; i < MAX_RES; i++) list_in[i].last = (3'(i) == n - 3'd1);
   end

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      num_in  = num_ff;
      if (take) begin
         busy_in = 1'b1; pos_in = 3'd0; num_in = n;
      end else if (busy_ff && out_ready) begin
         pos_in = pos_ff + 3'd1;
         if (pos_ff == num_ff - 3'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         op_ff    <= OP_NONE;
         addr_ff  <= '0;
         rem_ff   <= '0;
         id_ff    <= '0;
         wbi_ff   <= 1'b0;
         busy_ff  <= 1'b0;
         pos_ff   <= 3'd0;
         num_ff   <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
         num_ff  <= num_in;
         if (take) begin
            phase_ff <= phase_in;
            op_ff    <= op_in;
            addr_ff  <= addr_in;
            rem_ff   <= rem_in;
            id_ff    <= id_in;
            wbi_ff   <= wbi_in;
         end
      end
      if (take) list_ff <= list_in;
   end

`ifndef SYNTHESIS
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pos_ff < num_ff) else $error("result index beyond list");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      busy_ff && out_ready && out_res.last |=> !busy_ff || pos_ff == 3'd0)
      else $error("last without end");
   a_idle_op: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> op_ff == OP_NONE || op_ff == OP_PROT)
      else $error("idle with operation");
`endif
endmodule

### bench/spi_nor_flash_command_sequencer_top_test.sv
// ---------------------------------------------------------------------------
// spi_nor_flash_command_sequencer_top_test
// self-checking bench: drives flash requests, payload and reply transfers,
// predicts every spi frame byte and data result, and compares field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module spi_nor_flash_command_sequencer_top_test;
   import snfcs_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_WAIT  = 8;

   // csr indexes
   localparam logic CSR_WORD_MODE    = 1'b0;
   localparam logic CSR_LARGE_SECTOR = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [23:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;

   spi_nor_flash_command_sequencer_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // sequencer model: own copy of the phase, counters and registers
   // ------------------------------------------------------------------
   phase_type   seq_phase = PH_IDLE;
   op_type      seq_op = OP_NONE;
   logic [23:0] seq_addr = '0;
   logic [15:0] seq_left = '0;
   logic [23:0] seq_id = '0;
   logic        seq_word_half = 1'b0;
   logic        cfg_word_mode = 1'b0;
   logic [23:0] cfg_large_start = 24'h010000;

   result_type  frame_bytes[$];    // results of the item being predicted
   result_type  pending_results[$]; // predicted, not yet seen on rsp

   int fails = 0;
   int cycles = 0;
   int burst_left = 0;
   int hold_asks = 0;

   function automatic void put_byte(logic [7:0] b, logic rel, logic aw);
      result_type r;
      r = '0;
      r.tx_valid = 1'b1;
      r.tx_byte = b;
      r.release_cs = rel;
      r.await_reply = aw;
      frame_bytes.push_back(r);
   endfunction

   function automatic void put_blank();
      result_type r;
      r = '0;
      frame_bytes.push_back(r);
   endfunction

   function automatic void end_request();
      frame_bytes[frame_bytes.size()-1].op_done = 1'b1;
      seq_phase = PH_IDLE;
      seq_op = OP_NONE;
   endfunction

   function automatic void put_address(logic [23:0] a, logic rel_last);
      put_byte(a[23:16], 1'b0, 1'b0);
      put_byte(a[15:8], 1'b0, 1'b0);
      put_byte(a[7:0], rel_last, 1'b0);
   endfunction

   function automatic void begin_status_poll();
      put_byte(OPC_RDSR, 1'b0, 1'b0);
      put_byte(OPC_DUMMY, 1'b0, 1'b1);
      seq_phase = PH_POLL;
   endfunction

   function automatic void predict_frames(action_type act, logic [23:0] addr,
                                          logic [15:0] cnt, logic [7:0] pay,
                                          logic [7:0] rep);
      result_type r;
      frame_bytes.delete();
      if (act <= ACT_PROT) begin
         if (seq_phase != PH_IDLE) begin
            r = '0;
            r.error = 1'b1;
            frame_bytes.push_back(r);
         end else begin
            case (act)
               ACT_READ_ID: begin
                  seq_op = OP_ID;
                  seq_id = '0;
                  seq_left = 16'd3;
                  put_byte(OPC_RDID, 1'b0, 1'b0);
                  put_byte(OPC_DUMMY, 1'b0, 1'b1);
                  seq_phase = PH_ID;
               end
               ACT_READ: begin
                  if (cnt == 0) begin
                     put_blank();
                     end_request();
                  end else begin
                     seq_op = OP_READ;
                     seq_addr = addr;
                     seq_left = cnt;
                     put_byte(OPC_READ, 1'b0, 1'b0);
                     put_address(addr, 1'b0);
                     put_byte(OPC_DUMMY, cnt == 16'd1, 1'b1);
                     seq_phase = PH_READ;
                  end
               end
               ACT_PROGRAM: begin
                  // word mode drops an odd trailing byte
                  if (cfg_word_mode) cnt[0] = 1'b0;
                  if (cnt == 0) begin
                     put_blank();
                     end_request();
                  end else begin
                     seq_op = cfg_word_mode ? OP_WORD : OP_PAGE;
                     seq_addr = addr;
                     seq_left = cnt;
                     seq_word_half = 1'b0;
                     put_byte(OPC_WREN, 1'b1, 1'b0);
                     put_byte(cfg_word_mode ? OPC_AAI : OPC_PP, 1'b0, 1'b0);
                     put_address(addr, 1'b0);
                     seq_phase = PH_PAYLOAD;
                  end
               end
               ACT_ERASE: begin
                  seq_op = OP_ERASE;
                  seq_addr = addr;
                  put_byte(OPC_WREN, 1'b1, 1'b0);
                  put_byte(addr >= cfg_large_start ? OPC_SE64K : OPC_SE4K, 1'b0, 1'b0);
                  put_address(addr, 1'b1);
                  begin_status_poll();
               end
               ACT_CHIP: begin
                  seq_op = OP_ERASE;
                  put_byte(OPC_WREN, 1'b1, 1'b0);
                  put_byte(OPC_CE, 1'b1, 1'b0);
                  begin_status_poll();
               end
               default: begin
                  seq_op = OP_PROT;
                  put_byte(OPC_EWSR, 1'b1, 1'b0);
                  put_byte(WRSR_ARG, 1'b0, 1'b0);
                  put_byte(8'h00, 1'b1, 1'b0);
                  end_request();
               end
            endcase
         end
      end else if (act == ACT_PAYLOAD) begin
         if (seq_phase != PH_PAYLOAD) begin
            r = '0;
            r.error = 1'b1;
            frame_bytes.push_back(r);
         end else begin
            seq_addr = seq_addr + 24'd1;
            seq_left = seq_left - 16'd1;
            if (seq_op == OP_WORD && !seq_word_half) begin
               put_byte(pay, 1'b0, 1'b0);
               seq_word_half = 1'b1;
            end else if (seq_op == OP_WORD || seq_left == 0) begin
               // word complete or last page byte: deselect and poll
               seq_word_half = 1'b0;
               put_byte(pay, 1'b1, 1'b0);
               begin_status_poll();
            end else begin
               put_byte(pay, 1'b0, 1'b0);
            end
         end
      end else begin
         case (seq_phase)
            PH_ID: begin
               seq_id = {seq_id[15:0], rep};
               seq_left = seq_left - 16'd1;
               if (seq_left == 0) begin
                  r = '0;
                  r.id_valid = 1'b1;
                  r.device_id = seq_id;
                  frame_bytes.push_back(r);
                  end_request();
               end else begin
                  put_byte(OPC_DUMMY, seq_left == 16'd1, 1'b1);
               end
            end
            PH_READ: begin
               r = '0;
               r.read_valid = 1'b1;
               r.read_byte = rep;
               seq_addr = seq_addr + 24'd1;
               seq_left = seq_left - 16'd1;
               if (seq_left != 0) begin
                  r.tx_valid = 1'b1;
                  r.tx_byte = OPC_DUMMY;
                  r.await_reply = 1'b1;
                  r.release_cs = (seq_left == 16'd1);
               end
               frame_bytes.push_back(r);
               if (seq_left == 0) end_request();
            end
            PH_POLL: begin
               if (rep[0]) begin
                  put_byte(OPC_DUMMY, 1'b0, 1'b1);
               end else begin
                  // write in progress cleared: close the status frame
                  r = '0;
                  r.release_cs = 1'b1;
                  frame_bytes.push_back(r);
                  if (seq_op == OP_WORD && seq_left != 0) begin
                     put_byte(OPC_AAI, 1'b0, 1'b0);
                     seq_phase = PH_PAYLOAD;
                  end else if (seq_op == OP_WORD || seq_op == OP_PAGE) begin
                     put_byte(OPC_WRDI, 1'b1, 1'b0);
                     end_request();
                  end else begin
                     end_request();
                  end
               end
            end
            default: begin
               r = '0;
               r.error = 1'b1;
               frame_bytes.push_back(r);
            end
         endcase
      end
      frame_bytes[frame_bytes.size()-1].last = 1'b1;
      foreach (frame_bytes[i]) pending_results.push_back(frame_bytes[i]);
   endfunction

   // ------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------
   function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing expected: %0h", rsp_tdata);
            fails++;
         end else begin
            want = pending_results.pop_front();
            check_field("tx_valid", want.tx_valid, rsp_tdata[0]);
            check_field("tx_byte", want.tx_byte, rsp_tdata[8:1]);
            check_field("release_cs", want.release_cs, rsp_tdata[9]);
            check_field("await_reply", want.await_reply, rsp_tdata[10]);
            check_field("read_valid", want.read_valid, rsp_tdata[11]);
            check_field("read_byte", want.read_byte, rsp_tdata[19:12]);
            check_field("id_valid", want.id_valid, rsp_tdata[20]);
            check_field("device_id", want.device_id, rsp_tdata[44:21]);
            check_field("op_done", want.op_done, rsp_tdata[45]);
            check_field("error", want.error, rsp_tdata[46]);
            check_field("last", want.last, rsp_tlast);
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver: stall pattern rotates through four modes, plus long hold-offs
   // ------------------------------------------------------------------
   int hold_seen = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case ((cycles / 64) % 4)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= (cycles % 4) != 0;
            default: rsp_tready <= $urandom_range(0, 3) == 0;
         endcase
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------
   task automatic send_item(action_type act, logic [23:0] addr, logic [15:0] cnt,
                            logic [7:0] pay, logic [7:0] rep);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, rep, pay, cnt, addr, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_frames(act, addr, cnt, pay, rep);
   endtask

   // stop offering and wait for every predicted result
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [23:0] value);
      drain_results();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_WORD_MODE) cfg_word_mode = value[0];
      else cfg_large_start = value;
   endtask

   // one well-formed follow-up for the current phase
   task automatic send_follow_up();
      logic [7:0] rep;
      rep = 8'($urandom_range(0, 255));
      case (seq_phase)
         PH_PAYLOAD: send_item(ACT_PAYLOAD, 24'($urandom), 16'($urandom), 8'($urandom),
                               8'($urandom));
         PH_POLL: begin
            rep[0] = ($urandom_range(0, 2) == 0);
            send_item(ACT_REPLY, 24'($urandom), 16'($urandom), 8'($urandom), rep);
         end
         default: send_item(ACT_REPLY, 24'($urandom), 16'($urandom), 8'($urandom), rep);
      endcase
   endtask

   task automatic finish_request();
      while (seq_phase != PH_IDLE) send_follow_up();
   endtask

   function automatic logic [23:0] pick_address();
      case ($urandom_range(0, 5))
         0: return 24'hFFFFFF;
         1: return 24'h000000;
         2: return cfg_large_start;
         3: return cfg_large_start - 24'd1;
         default: return 24'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_default_requests();
      send_item(ACT_READ_ID, '0, '0, '0, '0);
      send_item(ACT_REPLY, '1, '1, '1, 8'hFF);
      send_item(ACT_REPLY, '0, '0, '0, 8'h00);
      send_item(ACT_REPLY, '0, '0, '0, 8'hA5);
      send_item(ACT_READ, 24'hFFFFFF, 16'd1, '0, '0);
      send_item(ACT_REPLY, '0, '0, '0, 8'h5A);
      send_item(ACT_READ, 24'h123456, 16'd3, '0, '0);
      finish_request();
      send_item(ACT_PROGRAM, 24'hFFFFFF, 16'd2, '0, '0);  // address wraps
      send_item(ACT_PAYLOAD, '0, '0, 8'hFF, '0);
      send_item(ACT_PAYLOAD, '0, '0, 8'h00, '0);
      send_item(ACT_REPLY, '0, '0, '0, 8'h01);           // still busy
      send_item(ACT_REPLY, '0, '0, '0, 8'hFE);           // ready
      send_item(ACT_ERASE, 24'h00FFFF, '0, '0, '0);      // 4 KB below the boundary
      finish_request();
      send_item(ACT_ERASE, 24'h010000, '0, '0, '0);      // 64 KB at the boundary
      finish_request();
      send_item(ACT_CHIP, '0, '0, '0, '0);
      finish_request();
      send_item(ACT_PROT, '0, '0, '0, '0);
   endtask

   task automatic test_special_cases();
      send_item(ACT_READ, 24'h000000, 16'd0, '0, '0);    // zero-length read
      send_item(ACT_PROGRAM, 24'h000000, 16'd0, '0, '0); // zero-length program
      send_item(ACT_PAYLOAD, '0, '0, 8'h33, '0);         // payload while idle
      send_item(ACT_REPLY, '0, '0, '0, 8'h00);           // reply while idle
      send_item(ACT_READ, 24'h0000AA, 16'd2, '0, '0);
      send_item(ACT_READ, 24'hFFFFFF, 16'hFFFF, '0, '0); // request while busy
      send_item(ACT_PAYLOAD, '0, '0, 8'h11, '0);         // payload during read
      finish_request();
   endtask

   task automatic test_word_mode();
      write_csr(CSR_WORD_MODE, 24'd1);
      send_item(ACT_PROGRAM, 24'h000000, 16'd1, '0, '0); // odd count drops to zero
      send_item(ACT_PROGRAM, 24'hFFFFFE, 16'd5, '0, '0); // two words
      send_item(ACT_REPLY, '0, '0, '0, 8'h00);           // reply during payload
      finish_request();
      write_csr(CSR_WORD_MODE, 24'd0);
   endtask

   task automatic test_sector_boundary();
      write_csr(CSR_LARGE_SECTOR, 24'h000000);
      send_item(ACT_ERASE, 24'h000000, '0, '0, '0);
      finish_request();
      write_csr(CSR_LARGE_SECTOR, 24'hFFFFFF);
      send_item(ACT_ERASE, 24'hFFFFFE, '0, '0, '0);
      finish_request();
      send_item(ACT_ERASE, 24'hFFFFFF, '0, '0, '0);
      finish_request();
   endtask

   // receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_backpressure();
      hold_asks++;
      send_item(ACT_READ, 24'($urandom), 16'd4, '0, '0);
      finish_request();
      send_item(ACT_CHIP, '0, '0, '0, '0);
      finish_request();
      drain_results();
   endtask

   task automatic test_random(int count);
      action_type act;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 15) begin
            // noise: stray payload/reply when idle, any request when busy
            if (seq_phase == PH_IDLE)
               act = action_type'($urandom_range(6, 7));
            else
               act = action_type'($urandom_range(0, 7));
            if (act == ACT_REPLY && seq_phase == PH_POLL) act = ACT_PAYLOAD;
            if (act == ACT_PAYLOAD && seq_phase == PH_PAYLOAD) act = ACT_READ_ID;
            send_item(act, 24'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
         end else if (seq_phase == PH_IDLE) begin
            act = action_type'($urandom_range(0, 5));
            send_item(act, pick_address(), 16'($urandom_range(0, 6)), 8'($urandom),
                      8'($urandom));
         end else begin
            send_follow_up();
         end
         if ($urandom_range(0, 39) == 0) begin
            finish_request();
            if ($urandom_range(0, 1)) write_csr(CSR_WORD_MODE, 24'($urandom_range(0, 1)));
            else write_csr(CSR_LARGE_SECTOR, 24'($urandom));
         end
      end
      finish_request();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      test_default_requests();
      test_special_cases();
      test_word_mode();
      test_sector_boundary();
      test_backpressure();
      write_csr(CSR_LARGE_SECTOR, 24'h010000);
      test_random(40);
      drain_results();
      repeat (20) @(posedge clock);
      if (fails == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
